### sv/tac_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_pkg
// Shared types and codes for the tile average color core.
// ----------------------------------------------------------------------------
package tac_pkg;

   // register indexes (paddr[3:2])
   localparam logic [1:0] REG_TILE_WIDTH   = 2'd0;
   localparam logic [1:0] REG_PIXEL_FORMAT = 2'd1;
   localparam logic [1:0] REG_FIRST_TILE   = 2'd2;
   localparam logic [1:0] REG_LAST_TILE    = 2'd3;

   // pixel formats
   localparam logic [1:0] FMT_PALETTE = 2'd0;
   localparam logic [1:0] FMT_RGB555  = 2'd1;

   localparam int unsigned TILE_NUM_W = 16;
   localparam int unsigned COLOR_W    = 8;
   localparam int unsigned PAL_WORD_W = 24;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

   // configuration side effects on the accumulator
   typedef struct packed {
      logic                  clear_tile;
      logic                  load_tile;
      logic [TILE_NUM_W-1:0] first_tile;
   } cfg_event_type;

   typedef struct packed {
      logic [TILE_NUM_W-1:0] tile_number;
      logic [COLOR_W-1:0]    avg_red;
      logic [COLOR_W-1:0]    avg_green;
      logic [COLOR_W-1:0]    avg_blue;
   } result_type;

endpackage

### sv/tile_average_color_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_average_color_core
// Averages the color of square tiles streamed in raster order.
//
// Usage:
//  - req channel (valid/stall): each transfer is a palette write
//    (req_command = 0) or one pixel of the current tile (req_command = 1).
//  - rsp channel (valid/stall): one transfer per finished tile carrying the
//    tile number and the truncated mean red, green and blue.
//  - APB-style CSR port: tile_width, pixel_format, first_tile, last_tile at
//    byte addresses 0, 4, 8, 12. Write only while the block is idle.
//  - Pixels enter one per cycle while req is not stalled. The palette RAM is
//    read at acceptance into the stage-1 register, from which the sums update.
//    The last pixel of a tile hands the sums to an eight-step divider, whose
//    result is loaded into the output register and offered on rsp.
//  - The divider handles one tile at a time: a tile that ends while it is
//    still busy stalls req until it frees up, so a new tile cannot close
//    before the divider is through with the last one.
//  - rsp has an output register: the divider keeps working while a result
//    waits, and stalls only when a second result is ready behind it.
//  - Reset (synchronous) clears the palette via per-entry valid bits,
//    clears the sums and loads the power-up register values; no clearing
//    pass is needed.
// ----------------------------------------------------------------------------
module tile_average_color_core #(
   parameter int unsigned MAX_TILE_WIDTH = 64,
   parameter int unsigned PALETTE_DEPTH  = 256
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [7:0]  req_palette_index,
   input  logic [23:0] req_palette_word,
   input  logic [15:0] req_pixel_value,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [15:0] rsp_tile_number,
   output logic [7:0]  rsp_avg_red,
   output logic [7:0]  rsp_avg_green,
   output logic [7:0]  rsp_avg_blue,
   // CSR port
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   localparam int unsigned SIDE_W = $clog2(MAX_TILE_WIDTH + 1);
   localparam int unsigned CNT_W  = $clog2(MAX_TILE_WIDTH * MAX_TILE_WIDTH + 1);
   localparam int unsigned SUM_W  = CNT_W + 8;
   localparam int unsigned PAL_AW = $clog2(PALETTE_DEPTH);
   localparam int unsigned RESET_SIDE  = (MAX_TILE_WIDTH < 32) ? MAX_TILE_WIDTH : 32;
   localparam int unsigned RESET_TOTAL = RESET_SIDE * RESET_SIDE;

   // ---------------- CSR ----------------
   logic [6:0]  tile_width_ff;
   logic [1:0]  pixel_format_ff;
   logic [15:0] first_tile_ff;
   logic [15:0] last_tile_ff;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [SIDE_W-1:0] side_wr;
   logic        csr_wr;
   logic [1:0]  csr_reg;
   tac_pkg::cfg_event_type cfg_evt;

   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite;
   assign csr_reg = paddr[3:2];

   // clamp the side to 1..MAX_TILE_WIDTH, then square it
   always_comb begin
      if (pwdata[6:0] == 7'd0) begin
         side_wr = SIDE_W'(1);
      end else if (32'(pwdata[6:0]) > MAX_TILE_WIDTH) begin
         side_wr = SIDE_W'(MAX_TILE_WIDTH);
      end else begin
         side_wr = SIDE_W'(pwdata[6:0]);
      end
      total_in = CNT_W'(side_wr) * CNT_W'(side_wr);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tile_width_ff   <= 7'd32;
         pixel_format_ff <= tac_pkg::FMT_PALETTE;
         first_tile_ff   <= '0;
         last_tile_ff    <= 16'hFFFF;
         total_ff        <= CNT_W'(RESET_TOTAL);
      end else if (csr_wr) begin
         case (csr_reg)
            tac_pkg::REG_TILE_WIDTH: begin
               tile_width_ff <= pwdata[6:0];
               total_ff      <= total_in;
            end
            tac_pkg::REG_PIXEL_FORMAT: begin
               pixel_format_ff <= pwdata[1:0];
            end
            tac_pkg::REG_FIRST_TILE: begin
               first_tile_ff <= pwdata[15:0];
            end
            tac_pkg::REG_LAST_TILE: begin
               last_tile_ff <= pwdata[15:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      case (csr_reg)
         tac_pkg::REG_TILE_WIDTH:   prdata = 32'(tile_width_ff);
         tac_pkg::REG_PIXEL_FORMAT: prdata = 32'(pixel_format_ff);
         tac_pkg::REG_FIRST_TILE:   prdata = 32'(first_tile_ff);
         tac_pkg::REG_LAST_TILE:    prdata = 32'(last_tile_ff);
         default:                   prdata = '0;
      endcase
   end

   // register writes that restart the tile or the stream
   always_comb begin
      cfg_evt.clear_tile = csr_wr && (csr_reg == tac_pkg::REG_TILE_WIDTH ||
                                      csr_reg == tac_pkg::REG_PIXEL_FORMAT ||
                                      csr_reg == tac_pkg::REG_FIRST_TILE);
      cfg_evt.load_tile  = csr_wr && (csr_reg == tac_pkg::REG_FIRST_TILE);
      cfg_evt.first_tile = pwdata[15:0];
   end

   // ---------------- stage 0: accept, palette access ----------------
   logic                     req_xfer;
   logic                     pal_wr_en, pal_rd_en;
   logic [PAL_AW-1:0]        pal_wr_addr, pal_rd_addr;
   logic [23:0]              pal_rd_data;
   logic [PALETTE_DEPTH-1:0] pal_vld_ff;
   logic                     hold;
   logic                     s1_valid_ff, s1_valid_in;

   assign req_stall   = s1_valid_ff && hold;
   assign req_xfer    = req_valid && !req_stall;
   assign pal_wr_en   = req_xfer && !req_command &&
                        (32'(req_palette_index) < PALETTE_DEPTH);
   assign pal_wr_addr = req_palette_index[PAL_AW-1:0];
   assign pal_rd_en   = req_xfer && req_command;
   assign pal_rd_addr = req_pixel_value[PAL_AW-1:0];

   // valid bits stand in for clearing the palette at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         pal_vld_ff <= '0;
      end else if (pal_wr_en) begin
         pal_vld_ff[pal_wr_addr] <= 1'b1;
      end
   end

   tac_ram #(
      .WIDTH (tac_pkg::PAL_WORD_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (pal_wr_addr),
      .wr_data (req_palette_word),
      .rd_en   (pal_rd_en),
      .rd_addr (pal_rd_addr),
      .rd_data (pal_rd_data)
   );

   // ---------------- stage 1: color convert, accumulate ----------------
   logic        s1_hit_ff;
   logic [15:0] s1_pixel_ff;
   logic [7:0]  pix_red, pix_green, pix_blue;

   always_comb begin
      if (req_xfer) begin
         s1_valid_in = req_command;
      end else begin
         s1_valid_in = s1_valid_ff && hold;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pal_rd_en) begin
         s1_hit_ff   <= (32'(req_pixel_value[7:0]) < PALETTE_DEPTH) &&
                        pal_vld_ff[pal_rd_addr];
         s1_pixel_ff <= req_pixel_value;
      end
   end

   always_comb begin
      pix_red   = '0;
      pix_green = '0;
      pix_blue  = '0;
      case (pixel_format_ff)
         tac_pkg::FMT_PALETTE: begin
            if (s1_hit_ff) begin
               pix_red   = pal_rd_data[7:0];
               pix_green = pal_rd_data[15:8];
               pix_blue  = pal_rd_data[23:16];
            end
         end
         tac_pkg::FMT_RGB555: begin
            pix_red   = {s1_pixel_ff[14:10], 3'b000};
            pix_green = {s1_pixel_ff[9:5], 3'b000};
            pix_blue  = {s1_pixel_ff[4:0], 3'b000};
         end
         default: begin
         end
      endcase
   end

   logic             div_busy, div_start;
   logic [SUM_W-1:0] red_sum, green_sum, blue_sum;
   logic [15:0]      tile_number;
   tac_pkg::result_type rsp_data;

   tac_accum #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
   ) u_accum (
      .clock       (clock),
      .reset       (reset),
      .cfg_evt     (cfg_evt),
      .last_tile   (last_tile_ff),
      .total       (total_ff),
      .pix_valid   (s1_valid_ff),
      .pix_red     (pix_red),
      .pix_green   (pix_green),
      .pix_blue    (pix_blue),
      .div_busy    (div_busy),
      .hold        (hold),
      .div_start   (div_start),
      .red_sum     (red_sum),
      .green_sum   (green_sum),
      .blue_sum    (blue_sum),
      .tile_number (tile_number)
   );

   // ---------------- divide and output ----------------
   tac_divider #(
      .CNT_W (CNT_W),
      .SUM_W (SUM_W)
   ) u_divider (
      .clock       (clock),
      .reset       (reset),
      .start       (div_start),
      .red_sum     (red_sum),
      .green_sum   (green_sum),
      .blue_sum    (blue_sum),
      .total       (total_ff),
      .tile_number (tile_number),
      .busy        (div_busy),
      .out_valid   (rsp_valid),
      .out_stall   (rsp_stall),
      .out_data    (rsp_data)
   );

   assign rsp_tile_number = rsp_data.tile_number;
   assign rsp_avg_red     = rsp_data.avg_red;
   assign rsp_avg_green   = rsp_data.avg_green;
   assign rsp_avg_blue    = rsp_data.avg_blue;

endmodule

### sv/tac_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_ram
// Generic single-write, single-read synchronous RAM, registered read.
// ----------------------------------------------------------------------------
module tac_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/tac_accum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_accum
// Per-tile color sums, pixel count, tile number and end-of-stream flag.
// ----------------------------------------------------------------------------
module tac_accum #(
   parameter int unsigned CNT_W = 13,
   parameter int unsigned SUM_W = 21
) (
   input  logic                           clock,
   input  logic                           reset,
   input  tac_pkg::cfg_event_type         cfg_evt,
   input  logic [tac_pkg::TILE_NUM_W-1:0] last_tile,
   input  logic [CNT_W-1:0]               total,
   input  logic                           pix_valid,
   input  logic [tac_pkg::COLOR_W-1:0]    pix_red,
   input  logic [tac_pkg::COLOR_W-1:0]    pix_green,
   input  logic [tac_pkg::COLOR_W-1:0]    pix_blue,
   input  logic                           div_busy,
   output logic                           hold,
   output logic                           div_start,
   output logic [SUM_W-1:0]               red_sum,
   output logic [SUM_W-1:0]               green_sum,
   output logic [SUM_W-1:0]               blue_sum,
   output logic [tac_pkg::TILE_NUM_W-1:0] tile_number
);

   logic [SUM_W-1:0]               red_ff, green_ff, blue_ff;
   logic [SUM_W-1:0]               red_in, green_in, blue_in;
   logic [CNT_W-1:0]               count_ff, count_in, count_inc;
   logic [tac_pkg::TILE_NUM_W-1:0] tile_ff, tile_in;
   logic                           finished_ff, finished_in;
   logic                           counted, complete;

   always_comb begin
      counted   = pix_valid && !finished_ff && (tile_ff <= last_tile);
      count_inc = count_ff + CNT_W'(1);
      complete  = count_inc >= total;
      red_sum   = red_ff + SUM_W'(pix_red);
      green_sum = green_ff + SUM_W'(pix_green);
      blue_sum  = blue_ff + SUM_W'(pix_blue);
      hold      = counted && complete && div_busy;
      div_start = counted && complete && !div_busy;

      red_in      = red_ff;
      green_in    = green_ff;
      blue_in     = blue_ff;
      count_in    = count_ff;
      tile_in     = tile_ff;
      finished_in = finished_ff;

      if (div_start) begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
         count_in = '0;
         tile_in  = tile_ff + tac_pkg::TILE_NUM_W'(1);
         if (tile_ff == last_tile) begin
            finished_in = 1'b1;
         end
      end else if (counted && !complete) begin
         red_in   = red_sum;
         green_in = green_sum;
         blue_in  = blue_sum;
         count_in = count_inc;
      end

      // config writes must only arrive while the pipe is empty; this block does not check it
      if (cfg_evt.clear_tile) begin
         red_in   = '0;
         green_in = '0;
         blue_in  = '0;
         count_in = '0;
      end
      if (cfg_evt.load_tile) begin
         tile_in     = cfg_evt.first_tile;
         finished_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_ff      <= '0;
         green_ff    <= '0;
         blue_ff     <= '0;
         count_ff    <= '0;
         tile_ff     <= '0;
         finished_ff <= 1'b0;
      end else begin
         red_ff      <= red_in;
         green_ff    <= green_in;
         blue_ff     <= blue_in;
         count_ff    <= count_in;
         tile_ff     <= tile_in;
         finished_ff <= finished_in;
      end
   end

   assign tile_number = tile_ff;

endmodule

### sv/tac_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_divider
// Three-lane restoring divider (shared divisor) with output register.
// Quotient is known to be below 256, so eight steps suffice.
// ----------------------------------------------------------------------------
module tac_divider #(
   parameter int unsigned CNT_W = 13,
   parameter int unsigned SUM_W = 21
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [SUM_W-1:0]               red_sum,
   input  logic [SUM_W-1:0]               green_sum,
   input  logic [SUM_W-1:0]               blue_sum,
   input  logic [CNT_W-1:0]               total,
   input  logic [tac_pkg::TILE_NUM_W-1:0] tile_number,
   output logic                           busy,
   output logic                           out_valid,
   input  logic                           out_stall,
   output tac_pkg::result_type            out_data
);

   localparam int unsigned QW = tac_pkg::COLOR_W;
   localparam int unsigned SW = $clog2(QW);

   tac_pkg::div_state_type state_ff, state_in;

   logic [SUM_W-1:0]               rem_r_ff, rem_g_ff, rem_b_ff;
   logic [SUM_W-1:0]               rem_r_in, rem_g_in, rem_b_in;
   logic [SUM_W-1:0]               dvs_ff;
   logic [QW-1:0]                  q_r_ff, q_g_ff, q_b_ff;
   logic [QW-1:0]                  q_r_in, q_g_in, q_b_in;
   logic [SW-1:0]                  step_ff;
   logic [tac_pkg::TILE_NUM_W-1:0] tile_ff;
   logic                           out_valid_ff, out_valid_in;
   logic                           load_out;
   tac_pkg::result_type            out_ff;

   // one restoring step per lane
   always_comb begin
      rem_r_in = rem_r_ff;
      rem_g_in = rem_g_ff;
      rem_b_in = rem_b_ff;
      q_r_in   = {q_r_ff[QW-2:0], 1'b0};
      q_g_in   = {q_g_ff[QW-2:0], 1'b0};
      q_b_in   = {q_b_ff[QW-2:0], 1'b0};
      if (rem_r_ff >= dvs_ff) begin
         rem_r_in  = rem_r_ff - dvs_ff;
         q_r_in[0] = 1'b1;
      end
      if (rem_g_ff >= dvs_ff) begin
         rem_g_in  = rem_g_ff - dvs_ff;
         q_g_in[0] = 1'b1;
      end
      if (rem_b_ff >= dvs_ff) begin
         rem_b_in  = rem_b_ff - dvs_ff;
         q_b_in[0] = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      load_out     = 1'b0;
      out_valid_in = out_valid_ff && out_stall;
      case (state_ff)
         tac_pkg::DIV_IDLE: begin
            if (start) begin
               state_in = tac_pkg::DIV_RUN;
            end
         end
         tac_pkg::DIV_RUN: begin
            if (step_ff == SW'(QW - 1)) begin
               state_in = tac_pkg::DIV_DONE;
            end
         end
         tac_pkg::DIV_DONE: begin
            if (!out_valid_ff || !out_stall) begin
               load_out     = 1'b1;
               out_valid_in = 1'b1;
               state_in     = tac_pkg::DIV_IDLE;
            end
         end
         default: begin
            state_in = tac_pkg::DIV_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tac_pkg::DIV_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == tac_pkg::DIV_IDLE && start) begin
         rem_r_ff <= red_sum;
         rem_g_ff <= green_sum;
         rem_b_ff <= blue_sum;
         dvs_ff   <= SUM_W'(total) << (QW - 1);
         q_r_ff   <= '0;
         q_g_ff   <= '0;
         q_b_ff   <= '0;
         step_ff  <= '0;
         tile_ff  <= tile_number;
      end else if (state_ff == tac_pkg::DIV_RUN) begin
         rem_r_ff <= rem_r_in;
         rem_g_ff <= rem_g_in;
         rem_b_ff <= rem_b_in;
         dvs_ff   <= dvs_ff >> 1;
         q_r_ff   <= q_r_in;
         q_g_ff   <= q_g_in;
         q_b_ff   <= q_b_in;
         step_ff  <= step_ff + SW'(1);
      end
      if (load_out) begin
         out_ff.tile_number <= tile_ff;
         out_ff.avg_red     <= q_r_ff;
         out_ff.avg_green   <= q_g_ff;
         out_ff.avg_blue    <= q_b_ff;
      end
   end

   assign busy      = state_ff != tac_pkg::DIV_IDLE;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

### sv/tac_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tac_checker
// Port-level checks for the tile average color core, bound to the top.
// ----------------------------------------------------------------------------
module tac_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [15:0] rsp_tile_number,
   input logic [7:0]  rsp_avg_red,
   input logic [7:0]  rsp_avg_green,
   input logic [7:0]  rsp_avg_blue
);

   // a stalled result stays offered
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("rsp_valid dropped while stalled");

   // a stalled result keeps its payload
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_tile_number) && $stable(rsp_avg_red)
                                 && $stable(rsp_avg_green) && $stable(rsp_avg_blue))
      else $error("rsp payload changed while stalled");

   // reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result offered right after reset");

   // reset empties the pixel pipe, so nothing can hold req off
   a_req_reset: assert property (@(posedge clock)
      reset |=> !req_stall)
      else $error("req stalled right after reset");

endmodule

bind tile_average_color_core tac_checker u_tac_checker (.*);

### tb/tile_average_color_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tile_average_color_core_test
// Self-checking bench for the tile average color core.
//
// Palette writes and pixels go in on req, one transfer per handshake, with
// random gaps. Every accepted transfer also runs through a cycle-free copy of
// the averaging rules kept here. That copy queues the color expected for each
// finished tile, and each rsp transfer is checked against the head of the
// queue. rsp is stalled at random. CSR writes happen only when the block has
// gone quiet, and each one is read back.
// ----------------------------------------------------------------------------
module tile_average_color_core_test;

   localparam logic CMD_PALETTE_WRITE = 1'b0;
   localparam logic CMD_PIXEL         = 1'b1;

   // formats with no color: they add black but still count pixels
   localparam logic [1:0] FMT_BLACK_A = 2'd2;
   localparam logic [1:0] FMT_BLACK_B = 2'd3;

   localparam int unsigned MAX_SIDE       = 64;
   localparam int unsigned SETTLE_CYCLES  = 24;      // divider latency plus margin
   localparam int unsigned RANDOM_ITEMS   = 600;
   localparam int unsigned PARTIAL_PIXELS = 150;
   localparam int unsigned CYCLE_LIMIT    = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_command = 1'b0;
   logic [7:0]  req_palette_index = '0;
   logic [23:0] req_palette_word = '0;
   logic [15:0] req_pixel_value = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [15:0] rsp_tile_number;
   logic [7:0]  rsp_avg_red;
   logic [7:0]  rsp_avg_green;
   logic [7:0]  rsp_avg_blue;
   logic        psel = 1'b0;
   logic        penable = 1'b0;
   logic        pwrite = 1'b0;
   logic [3:0]  paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic        pready;

   tile_average_color_core i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_command       (req_command),
      .req_palette_index (req_palette_index),
      .req_palette_word  (req_palette_word),
      .req_pixel_value   (req_pixel_value),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tile_number   (rsp_tile_number),
      .rsp_avg_red       (rsp_avg_red),
      .rsp_avg_green     (rsp_avg_green),
      .rsp_avg_blue      (rsp_avg_blue),
      .psel              (psel),
      .penable           (penable),
      .pwrite            (pwrite),
      .paddr             (paddr),
      .pwdata            (pwdata),
      .prdata            (prdata),
      .pready            (pready)
   );

   // ---- shadow of the block's state -------------------------------------
   logic [23:0] palette_shadow [0:255];
   logic [19:0] red_total;
   logic [19:0] green_total;
   logic [19:0] blue_total;
   logic [12:0] pixels_in_tile;
   logic [15:0] next_tile;
   bit          stream_done;
   logic [6:0]  cfg_tile_width;
   logic [1:0]  cfg_format;
   logic [15:0] cfg_first_tile;
   logic [15:0] cfg_last_tile;

   tac_pkg::result_type tiles_due [$];      // colors owed by the block, oldest first

   int unsigned mismatch_count = 0;
   int unsigned tiles_checked  = 0;
   int unsigned pixels_sent    = 0;
   int unsigned palette_writes = 0;
   int unsigned reg_writes     = 0;
   int unsigned cycle_count    = 0;
   int unsigned rsp_hold       = 0;
   bit          quiet_req      = 1'b0;
   bit          quiet_rsp      = 1'b0;

   // ---- clock, watchdog ---------------------------------------------------
   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count++;
      // now and then switch a side into a stretch with no idling
      if (cycle_count % 400 == 0) begin
         quiet_req = ($urandom_range(0, 3) == 0);
         quiet_rsp = ($urandom_range(0, 3) == 0);
      end
      if (cycle_count == CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d tiles still owed",
                  $time, cycle_count, tiles_due.size());
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // mostly short gaps, a few long ones
   function automatic int unsigned pick_gap(bit quiet);
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (quiet || roll < 55) return 0;
      if (roll < 85) return $urandom_range(1, 3);
      if (roll < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 80);
   endfunction

   // ---- rsp back-pressure -------------------------------------------------
   always @(negedge clock) begin
      if (rsp_hold != 0) begin
         rsp_hold--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_hold = pick_gap(quiet_rsp);
         rsp_stall <= (rsp_hold != 0);
      end
   end

   // ---- shadow model ------------------------------------------------------
   task automatic restart_tile();
      red_total      = '0;
      green_total    = '0;
      blue_total     = '0;
      pixels_in_tile = '0;
   endtask

   task automatic shadow_reset();
      foreach (palette_shadow[i]) palette_shadow[i] = '0;
      cfg_tile_width = 7'd32;
      cfg_format     = tac_pkg::FMT_PALETTE;
      cfg_first_tile = 16'd0;
      cfg_last_tile  = 16'hFFFF;
      next_tile      = cfg_first_tile;
      stream_done    = 1'b0;
      restart_tile();
   endtask

   task automatic shadow_register(input logic [1:0] index, input logic [31:0] value);
      case (index)
         tac_pkg::REG_TILE_WIDTH: begin
            cfg_tile_width = value[6:0];
            restart_tile();
         end
         tac_pkg::REG_PIXEL_FORMAT: begin
            cfg_format = value[1:0];
            restart_tile();
         end
         tac_pkg::REG_FIRST_TILE: begin
            // restarts the stream
            cfg_first_tile = value[15:0];
            next_tile      = value[15:0];
            stream_done    = 1'b0;
            restart_tile();
         end
         tac_pkg::REG_LAST_TILE: begin
            cfg_last_tile = value[15:0];
         end
         default: begin
         end
      endcase
   endtask

   // Folds one accepted transfer into the running tile and queues the color
   // when it closes a tile. taken is low for a pixel the block drops.
   task automatic shadow_transfer(input logic cmd, input logic [7:0] index,
                                  input logic [23:0] word, input logic [15:0] pixel,
                                  output bit taken);
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      int unsigned side;
      int unsigned area;
      tac_pkg::result_type color;
      red   = '0;
      green = '0;
      blue  = '0;
      taken = 1'b1;
      if (cmd == CMD_PALETTE_WRITE) begin
         palette_shadow[index] = word;
         palette_writes++;
      end else if (stream_done || next_tile > cfg_last_tile) begin
         taken = 1'b0;
      end else begin
         pixels_sent++;
         if (cfg_format == tac_pkg::FMT_PALETTE) begin
            // only the low byte selects an entry
            red   = palette_shadow[pixel[7:0]][7:0];
            green = palette_shadow[pixel[7:0]][15:8];
            blue  = palette_shadow[pixel[7:0]][23:16];
         end else if (cfg_format == tac_pkg::FMT_RGB555) begin
            red   = {pixel[14:10], 3'b000};
            green = {pixel[9:5], 3'b000};
            blue  = {pixel[4:0], 3'b000};
         end
         red_total      += red;
         green_total    += green;
         blue_total     += blue;
         pixels_in_tile += 13'd1;

         side = 32'(cfg_tile_width);
         if (side == 0) side = 1;
         if (side > MAX_SIDE) side = MAX_SIDE;
         area = side * side;
         if (pixels_in_tile >= area) begin
            color.tile_number = next_tile;
            color.avg_red     = 8'(red_total / area);
            color.avg_green   = 8'(green_total / area);
            color.avg_blue    = 8'(blue_total / area);
            tiles_due.push_back(color);
            restart_tile();
            if (next_tile == cfg_last_tile) stream_done = 1'b1;
            next_tile = next_tile + 16'd1;
         end
      end
   endtask

   // ---- result checker ----------------------------------------------------
   task automatic check_field(input string name, input int unsigned expected,
                              input int unsigned actual);
      if (expected != actual) begin
         mismatch_count++;
         $display("%0t: %s expected %0d, got %0d", $time, name, expected, actual);
      end
   endtask

   always @(posedge clock) begin
      tac_pkg::result_type owed;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (tiles_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: unexpected tile: expected none, got tile %0d color %0d/%0d/%0d",
                     $time, rsp_tile_number, rsp_avg_red, rsp_avg_green, rsp_avg_blue);
         end else begin
            owed = tiles_due.pop_front();
            tiles_checked++;
            check_field("tile_number", 32'(owed.tile_number), 32'(rsp_tile_number));
            check_field("avg_red", 32'(owed.avg_red), 32'(rsp_avg_red));
            check_field("avg_green", 32'(owed.avg_green), 32'(rsp_avg_green));
            check_field("avg_blue", 32'(owed.avg_blue), 32'(rsp_avg_blue));
         end
      end
   end

   // ---- drivers -----------------------------------------------------------
   // One req transfer. Ends right after the accepting edge; valid is left
   // high so a back-to-back transfer never lowers and raises it in one step.
   task automatic send_item(input logic cmd, input logic [7:0] index,
                            input logic [23:0] word, input logic [15:0] pixel,
                            output bit taken);
      int unsigned gap;
      @(negedge clock);
      gap = pick_gap(quiet_req);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_palette_index <= index;
      req_palette_word  <= word;
      req_pixel_value   <= pixel;
      do @(posedge clock); while (req_stall);
      shadow_transfer(cmd, index, word, pixel, taken);
   endtask

   task automatic send_pixel(input logic [15:0] pixel);
      bit taken;
      send_item(CMD_PIXEL, 8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'hFFFFFF)),
                pixel, taken);
   endtask

   task automatic send_palette(input logic [7:0] index, input logic [23:0] word);
      bit taken;
      send_item(CMD_PALETTE_WRITE, index, word, 16'($urandom_range(0, 16'hFFFF)), taken);
   endtask

   // Drop valid, wait for every owed tile, then give the divider time to
   // finish anything a dropped or partial pixel may have left in flight.
   task automatic settle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (tiles_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write followed by a read-back of the same register.
   task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
      logic [31:0] width_mask;
      logic [31:0] readback;
      case (index)
         tac_pkg::REG_TILE_WIDTH:   width_mask = 32'h7F;
         tac_pkg::REG_PIXEL_FORMAT: width_mask = 32'h3;
         default:                   width_mask = 32'hFFFF;
      endcase
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {index, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      shadow_register(index, value);
      reg_writes++;
      @(negedge clock);
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      readback = prdata;
      if ((readback & width_mask) != (value & width_mask)) begin
         mismatch_count++;
         $display("%0t: register %0d read back expected %0h, got %0h",
                  $time, index, value & width_mask, readback & width_mask);
      end
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
   endtask

   // ---- tests -------------------------------------------------------------
   // Power-up values: 32x32 tiles, palette format, tile 0 first, cleared
   // palette, so the first tile must come out black.
   task automatic test_power_up();
      repeat (32 * 32) send_pixel(16'($urandom_range(0, 16'hFFFF)));
      settle();
   endtask

   // One-pixel tiles through every format, palette byte order, bits that
   // must be ignored, and truncation on a 2x2 tile.
   task automatic test_formats();
      write_reg(tac_pkg::REG_TILE_WIDTH, 0);     // zero acts as one
      write_reg(tac_pkg::REG_PIXEL_FORMAT, 32'(tac_pkg::FMT_PALETTE));
      send_palette(8'h00, 24'hFFFFFF);
      send_palette(8'hFF, 24'h563412);
      send_palette(8'h80, 24'h000000);
      send_pixel(16'hFF00);                      // high byte ignored
      send_pixel(16'h00FF);
      send_pixel(16'h5A80);
      send_palette(8'h00, 24'h0000FF);           // overwrite
      send_pixel(16'h0000);
      settle();
      write_reg(tac_pkg::REG_PIXEL_FORMAT, 32'(tac_pkg::FMT_RGB555));
      send_pixel(16'h7FFF);
      send_pixel(16'hFFFF);                      // top bit ignored
      send_pixel(16'h8000);
      send_pixel(16'h001F);
      send_pixel(16'h03E0);
      send_pixel(16'h7C00);
      settle();
      write_reg(tac_pkg::REG_PIXEL_FORMAT, 32'(FMT_BLACK_A));
      send_pixel(16'hFFFF);
      settle();
      write_reg(tac_pkg::REG_PIXEL_FORMAT, 32'(FMT_BLACK_B));
      send_pixel(16'h7FFF);
      settle();
      write_reg(tac_pkg::REG_TILE_WIDTH, 2);
      write_reg(tac_pkg::REG_PIXEL_FORMAT, 32'(tac_pkg::FMT_RGB555));
      send_pixel(16'h7FFF);
      send_pixel(16'h0000);
      send_pixel(16'h0001);
      send_pixel(16'h0421);
      settle();
   endtask

   // Tile numbering at the top of the range, the stop after last_tile, and
   // a first tile beyond the last one.
   task automatic test_tile_range();
      write_reg(tac_pkg::REG_TILE_WIDTH, 1);
      write_reg(tac_pkg::REG_LAST_TILE, 32'hFFFF);
      write_reg(tac_pkg::REG_FIRST_TILE, 32'hFFFE);
      send_pixel(16'h1234);
      send_pixel(16'h4321);
      send_pixel(16'h7FFF);                      // past the last tile: no wrap
      settle();
      write_reg(tac_pkg::REG_LAST_TILE, 32'hFFFF);   // stop flag survives
      send_pixel(16'h0F0F);
      send_palette(8'h11, 24'hABCDEF);           // palette still writable
      settle();
      write_reg(tac_pkg::REG_FIRST_TILE, 7);
      write_reg(tac_pkg::REG_LAST_TILE, 5);
      send_pixel(16'h0011);                      // first beyond last: dropped
      settle();
      write_reg(tac_pkg::REG_LAST_TILE, 7);
      write_reg(tac_pkg::REG_PIXEL_FORMAT, 32'(tac_pkg::FMT_PALETTE));
      send_pixel(16'h0011);
      send_pixel(16'h0011);
      settle();
      write_reg(tac_pkg::REG_FIRST_TILE, 0);
      write_reg(tac_pkg::REG_LAST_TILE, 32'hFFFF);
   endtask

   // Wide tiles: a width above the maximum and the maximum itself both make
   // large tiles, so a partial tile of full-scale color owes nothing.
   task automatic test_large_tiles();
      settle();
      write_reg(tac_pkg::REG_TILE_WIDTH, 127);
      write_reg(tac_pkg::REG_PIXEL_FORMAT, 32'(tac_pkg::FMT_PALETTE));
      send_palette(8'hAB, 24'hFFFFFF);
      repeat (PARTIAL_PIXELS) send_pixel({8'($urandom_range(0, 255)), 8'hAB});
      settle();
      write_reg(tac_pkg::REG_TILE_WIDTH, MAX_SIDE);
      write_reg(tac_pkg::REG_PIXEL_FORMAT, 32'(tac_pkg::FMT_RGB555));
      repeat (PARTIAL_PIXELS) send_pixel(16'($urandom_range(0, 16'hFFFF)));
      settle();
   endtask

   function automatic logic [31:0] pick_width();
      int unsigned roll;
      roll = $urandom_range(0, 99);
      if (roll < 8) return 0;
      if (roll < 70) return $urandom_range(1, 3);
      if (roll < 95) return $urandom_range(4, 6);
      return $urandom_range(7, 10);
   endfunction

   // Phases of mixed palette writes and pixels; between phases a random
   // subset of registers is rewritten, often cutting a tile short.
   task automatic test_random_traffic();
      int unsigned useful;
      int unsigned span;
      int unsigned roll;
      logic [15:0] first;
      logic        cmd;
      bit          taken;
      useful = 0;
      while (useful < RANDOM_ITEMS) begin
         settle();
         if ($urandom_range(0, 1)) write_reg(tac_pkg::REG_TILE_WIDTH, pick_width());
         if ($urandom_range(0, 1))
            write_reg(tac_pkg::REG_PIXEL_FORMAT, $urandom_range(0, 3));
         if ($urandom_range(0, 1)) begin
            first = ($urandom_range(0, 99) < 20) ? 16'($urandom_range(65530, 65535))
                                                 : 16'($urandom_range(0, 16'hFFFF));
            write_reg(tac_pkg::REG_FIRST_TILE, 32'(first));
            roll = $urandom_range(0, 99);
            if (roll < 60)
               write_reg(tac_pkg::REG_LAST_TILE, 32'hFFFF);
            else if (roll < 85)
               write_reg(tac_pkg::REG_LAST_TILE,
                         32'(16'(first + $urandom_range(0, 20))));
            else
               write_reg(tac_pkg::REG_LAST_TILE, $urandom_range(0, 16'hFFFF));
         end
         span = $urandom_range(10, 150);
         repeat (span) begin
            cmd = ($urandom_range(0, 99) < 20) ? CMD_PALETTE_WRITE : CMD_PIXEL;
            send_item(cmd, 8'($urandom_range(0, 255)), 24'($urandom_range(0, 24'hFFFFFF)),
                      16'($urandom_range(0, 16'hFFFF)), taken);
            if (taken) useful++;
         end
      end
   endtask

   // ---- sequence ----------------------------------------------------------
   initial begin
      shadow_reset();
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_power_up();
      test_formats();
      test_tile_range();
      test_large_tiles();
      test_random_traffic();
      settle();

      $display("Run covered %0d tiles from %0d pixels, %0d palette writes, %0d CSR writes.",
               tiles_checked, pixels_sent, palette_writes, reg_writes);
      $display("Tile widths 0 to 127, all four formats, tile numbers up to the top.");
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
